// ===== src/paids_pkg.sv =====
package paids_pkg;

    localparam int DEPTH   = 128;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = ADDR_W + 1;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int ERR_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } t_err;

endpackage

// ===== src/paids_ram.sv =====
module paids_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/positional_array_insert_delete_search.sv =====
// Clear, append, delete of the last entry, rejects and unused codes finish without a memory
// walk, and read makes one memory read; insert and delete shift the entries from the position
// to the end of the live entries, and search scans up from index 0 until the first match or the
// last live entry. One request at a time: the next is taken once the result is registered.
// Reset is synchronous and active low; it empties the array and drops any pending result.
// The entry memory is not cleared; only entries below the live count are ever read.
module positional_array_insert_delete_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [paids_pkg::CMD_W-1:0]   i_cmd,
    input  logic [paids_pkg::ADDR_W-1:0]  i_position,
    input  logic signed [paids_pkg::DATA_W-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_found,
    output logic [paids_pkg::ADDR_W-1:0]  o_match_index,
    output logic signed [paids_pkg::DATA_W-1:0] o_read_data,
    output logic [paids_pkg::COUNT_W-1:0] o_entry_count,
    output logic [paids_pkg::ERR_W-1:0]   o_error
);

    import paids_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_DEL  = 6'b000100,
        S_SRCH = 6'b001000,
        S_READ = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [COUNT_W-1:0]       r_count, n_count;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic [DATA_W-1:0]        r_val, n_val;
    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic                     r_rd_go, n_rd_go;
    logic                     r_pend, n_pend;
    logic [ADDR_W-1:0]        r_wr_addr, n_wr_addr;

    logic                     r_found, n_found;
    logic [ADDR_W-1:0]        r_match, n_match;
    logic [DATA_W-1:0]        r_rdata, n_rdata;
    logic [ERR_W-1:0]         r_err, n_err;

    logic                     r_o_valid;
    logic                     r_o_found;
    logic [ADDR_W-1:0]        r_o_match;
    logic [DATA_W-1:0]        r_o_rdata;
    logic [COUNT_W-1:0]       r_o_count;
    logic [ERR_W-1:0]         r_o_err;

    logic                     accept;
    logic                     out_free;
    logic                     load_out;
    logic [ADDR_W-1:0]        last_idx;
    logic [COUNT_W-1:0]       pos_ext;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [DATA_W-1:0]        mem_rdata;

    paids_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign load_out = (r_state == S_DONE) && out_free;
    assign last_idx = ADDR_W'(r_count - COUNT_W'(1));
    assign pos_ext  = {1'b0, i_position};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_val     = r_val;
        n_addr    = r_addr;
        n_rd_go   = r_rd_go;
        n_pend    = 1'b0;
        n_wr_addr = r_wr_addr;
        n_found   = r_found;
        n_match   = r_match;
        n_rdata   = r_rdata;
        n_err     = r_err;
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos   = i_position;
                    n_val   = i_value;
                    n_found = 1'b0;
                    n_match = '0;
                    n_rdata = '0;
                    n_err   = ERR_OK;
                    n_rd_go = 1'b0;
                    n_state = S_DONE;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (r_count == COUNT_W'(DEPTH)) begin
                                n_err = ERR_FULL;
                            end else if (pos_ext > r_count) begin
                                n_err = ERR_RANGE;
                            end else if (pos_ext == r_count) begin
                                mem_we    = 1'b1;
                                mem_waddr = i_position;
                                mem_wdata = i_value;
                                n_count   = r_count + COUNT_W'(1);
                            end else begin
                                n_addr  = last_idx;
                                n_rd_go = 1'b1;
                                n_state = S_INS;
                            end
                        end
                        CMD_DELETE: begin
                            if (pos_ext >= r_count) begin
                                n_err = ERR_RANGE;
                            end else if (i_position == last_idx) begin
                                n_count = r_count - COUNT_W'(1);
                            end else begin
                                n_addr  = i_position + ADDR_W'(1);
                                n_rd_go = 1'b1;
                                n_state = S_DEL;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count != '0) begin
                                n_addr  = '0;
                                n_rd_go = 1'b1;
                                n_state = S_SRCH;
                            end
                        end
                        CMD_READ: begin
                            if (pos_ext >= r_count) begin
                                n_err = ERR_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = i_position;
                                n_state   = S_READ;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_rd_go) begin
                    mem_re    = 1'b1;
                    n_pend    = 1'b1;
                    n_wr_addr = r_addr + ADDR_W'(1);
                    if (r_addr == r_pos) begin
                        n_rd_go = 1'b0;
                    end else begin
                        n_addr = r_addr - ADDR_W'(1);
                    end
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                end else if (!r_rd_go) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_val;
                    n_count   = r_count + COUNT_W'(1);
                    n_state   = S_DONE;
                end
            end
            S_DEL: begin
                if (r_rd_go) begin
                    mem_re    = 1'b1;
                    n_pend    = 1'b1;
                    n_wr_addr = r_addr - ADDR_W'(1);
                    if (r_addr == last_idx) begin
                        n_rd_go = 1'b0;
                    end else begin
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                end else if (!r_rd_go) begin
                    n_count = r_count - COUNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_SRCH: begin
                if (r_rd_go) begin
                    mem_re    = 1'b1;
                    n_pend    = 1'b1;
                    n_wr_addr = r_addr;
                    if (r_addr == last_idx) begin
                        n_rd_go = 1'b0;
                    end else begin
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end
                if (r_pend && (mem_rdata == r_val)) begin
                    n_found = 1'b1;
                    n_match = r_wr_addr;
                    n_rd_go = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (!r_pend && !r_rd_go) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_rdata = mem_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_go   <= 1'b0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_go <= n_rd_go;
            r_pend  <= n_pend;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_addr    <= n_addr;
        r_wr_addr <= n_wr_addr;
        r_found   <= n_found;
        r_match   <= n_match;
        r_rdata   <= n_rdata;
        r_err     <= n_err;
        if (load_out) begin
            r_o_found <= r_found;
            r_o_match <= r_match;
            r_o_rdata <= r_rdata;
            r_o_count <= r_count;
            r_o_err   <= r_err;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_found       = r_o_found;
    assign o_match_index = r_o_match;
    assign o_read_data   = r_o_rdata;
    assign o_entry_count = r_o_count;
    assign o_error       = r_o_err;

endmodule

// ===== dv/positional_array_insert_delete_search_test.sv =====
module positional_array_insert_delete_search_test;
    import paids_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO  = CMD_CLEAR + 1;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = CMD_CLEAR + 2;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI  = '1;
    localparam logic signed [DATA_W-1:0] MAX_WORD = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_REQUESTS = 342;

    typedef struct {
        logic                     found;
        logic [ADDR_W-1:0]        match_index;
        logic signed [DATA_W-1:0] read_data;
        logic [COUNT_W-1:0]       entry_count;
        logic [ERR_W-1:0]         error;
    } t_outcome;

    class array_shadow;
        logic signed [DATA_W-1:0] entries [DEPTH];
        int live;
        int peak;
        int failures;
        int results_seen;
        int requests_seen;
        int per_cmd [8];
        int rejects_full;
        int rejects_range;
        int hits;
        t_outcome pending_results [$];

        function new();
            live          = 0;
            peak          = 0;
            failures      = 0;
            results_seen  = 0;
            requests_seen = 0;
            rejects_full  = 0;
            rejects_range = 0;
            hits          = 0;
            foreach (per_cmd[k]) per_cmd[k] = 0;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            t_outcome r;
            int p;
            p             = pos;
            r.found       = 1'b0;
            r.match_index = '0;
            r.read_data   = '0;
            r.error       = ERR_OK;
            requests_seen++;
            per_cmd[cmd]++;
            case (cmd)
                CMD_INSERT: begin
                    if (live >= DEPTH) begin
                        r.error = ERR_FULL;
                    end else if (p > live) begin
                        r.error = ERR_RANGE;
                    end else begin
                        for (int i = live; i > p; i--) entries[i] = entries[i-1];
                        entries[p] = val;
                        live++;
                    end
                end
                CMD_DELETE: begin
                    if (p >= live) begin
                        r.error = ERR_RANGE;
                    end else begin
                        for (int i = p; i + 1 < live; i++) entries[i] = entries[i+1];
                        live--;
                    end
                end
                CMD_SEARCH: begin
                    for (int i = 0; i < live; i++) begin
                        if (!r.found && entries[i] == val) begin
                            r.found       = 1'b1;
                            r.match_index = ADDR_W'(i);
                        end
                    end
                    if (r.found) hits++;
                end
                CMD_READ: begin
                    if (p >= live) r.error = ERR_RANGE;
                    else r.read_data = entries[p];
                end
                CMD_CLEAR: begin
                    live = 0;
                end
                default: begin
                end
            endcase
            if (r.error == ERR_FULL) rejects_full++;
            if (r.error == ERR_RANGE) rejects_range++;
            if (live > peak) peak = live;
            r.entry_count = COUNT_W'(live);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
                failures++;
            end
        endfunction

        function void check_result(logic found, logic [ADDR_W-1:0] match_index,
                                   logic signed [DATA_W-1:0] read_data,
                                   logic [COUNT_W-1:0] entry_count, logic [ERR_W-1:0] error);
            t_outcome want;
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
            end else begin
                want = pending_results.pop_front();
                compare_field("found", want.found, found);
                compare_field("match_index", want.match_index, match_index);
                compare_field("read_data", want.read_data, read_data);
                compare_field("entry_count", want.entry_count, entry_count);
                compare_field("error", want.error, error);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [CMD_W-1:0]         i_cmd = CMD_SEARCH;
    logic [ADDR_W-1:0]        i_position = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic                     o_found;
    logic [ADDR_W-1:0]        o_match_index;
    logic signed [DATA_W-1:0] o_read_data;
    logic [COUNT_W-1:0]       o_entry_count;
    logic [ERR_W-1:0]         o_error;

    array_shadow shadow;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_due = 1'b0;

    positional_array_insert_delete_search uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_cmd(i_cmd),
        .i_position(i_position),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_found(o_found),
        .o_match_index(o_match_index),
        .o_read_data(o_read_data),
        .o_entry_count(o_entry_count),
        .o_error(o_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // The result side stalls at random, and once holds off long enough for the block
    // to back up and refuse new requests.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_due) begin
                hold_due = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            shadow.check_result(o_found, o_match_index, o_read_data, o_entry_count, o_error);
        end
    end

    function automatic int draw_gap(int pct);
        int g;
        g = 0;
        while (g < 40 && $urandom_range(99) < pct) g++;
        return g;
    endfunction

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] pos,
                                logic signed [DATA_W-1:0] val);
        int gap;
        gap = draw_gap(send_idle_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shadow.note_request(cmd, pos, val);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: v = MAX_WORD;
                    1: v = MIN_WORD;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            1, 2, 3: v = $signed($urandom_range(15)) - 8;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_position(int span);
        if (span > DEPTH) span = DEPTH;
        if (span > 0 && $urandom_range(99) < 88) return ADDR_W'($urandom_range(span - 1));
        return ADDR_W'($urandom_range(DEPTH - 1));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_key();
        if (shadow.live > 0 && $urandom_range(99) < 60) begin
            return shadow.entries[$urandom_range(shadow.live - 1)];
        end
        return pick_value();
    endfunction

    task automatic random_request();
        int r;
        int ins_w;
        r     = $urandom_range(99);
        ins_w = (shadow.live < 96) ? 45 : 20;
        if (r < ins_w) begin
            send_request(CMD_INSERT, pick_position(shadow.live + 1), pick_value());
        end else if (r < ins_w + 22) begin
            send_request(CMD_DELETE, pick_position(shadow.live), pick_value());
        end else if (r < ins_w + 38) begin
            send_request(CMD_SEARCH, ADDR_W'($urandom_range(DEPTH - 1)), pick_key());
        end else if (r < ins_w + 50) begin
            send_request(CMD_READ, pick_position(shadow.live), pick_value());
        end else if (r < ins_w + 52) begin
            send_request(CMD_CLEAR, ADDR_W'($urandom_range(DEPTH - 1)), pick_value());
        end else if (r < ins_w + 54) begin
            send_request(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                         ADDR_W'($urandom_range(DEPTH - 1)), pick_value());
        end else begin
            send_request(CMD_SEARCH, ADDR_W'($urandom_range(DEPTH - 1)), pick_key());
        end
    endtask

    // Grows the array to capacity, then probes both ends of a full array.
    task automatic fill_table();
        while (shadow.live < DEPTH) begin
            send_request(CMD_INSERT, ADDR_W'($urandom_range(shadow.live)), pick_value());
        end
        send_request(CMD_INSERT, DEPTH - 1, pick_value());
        send_request(CMD_INSERT, 0, pick_value());
        send_request(CMD_SEARCH, 0, shadow.entries[DEPTH - 1]);
        send_request(CMD_SEARCH, 0, pick_value());
        send_request(CMD_READ, DEPTH - 1, '0);
        send_request(CMD_DELETE, DEPTH - 1, '0);
        send_request(CMD_INSERT, DEPTH - 1, MIN_WORD);
    endtask

    initial begin
        int target;
        shadow = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_SEARCH, 0, '0);
        send_request(CMD_READ, 0, '0);
        send_request(CMD_DELETE, 0, '0);
        send_request(CMD_INSERT, 1, '1);
        send_request(CMD_INSERT, 0, MAX_WORD);
        send_request(CMD_INSERT, 0, MIN_WORD);
        send_request(CMD_INSERT, 2, '1);
        send_request(CMD_INSERT, 1, '0);
        send_request(CMD_SEARCH, DEPTH - 1, MAX_WORD);
        send_request(CMD_SEARCH, 0, '1);
        send_request(CMD_SEARCH, 0, 12345);
        send_request(CMD_READ, 0, '0);
        send_request(CMD_READ, 3, '0);
        send_request(CMD_READ, DEPTH - 1, '0);
        send_request(CMD_DELETE, DEPTH - 1, '0);
        send_request(CMD_INSERT, DEPTH - 1, MAX_WORD);
        send_request(CMD_DELETE, 1, '0);
        send_request(CMD_DELETE, 0, '0);
        send_request(CMD_SPARE_LO, 0, '0);
        send_request(CMD_SPARE_MID, DEPTH - 1, MAX_WORD);
        send_request(CMD_SPARE_HI, DEPTH - 1, '1);
        send_request(CMD_INSERT, 0, '1);
        send_request(CMD_SEARCH, 0, '1);
        send_request(CMD_CLEAR, DEPTH - 1, MIN_WORD);
        send_request(CMD_SEARCH, 0, '1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 62;
                    hold_due      = 1'b1;
                end
                1: begin
                    send_idle_pct = 62;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = shadow.requests_seen + PHASE_REQUESTS;
            fill_table();
            while (shadow.requests_seen < target) random_request();
        end
        i_valid <= 1'b0;

        while (shadow.pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);

        $display("Issued %0d requests: %0d inserts, %0d deletes, %0d searches (%0d hits), %0d reads,",
                 shadow.requests_seen, shadow.per_cmd[CMD_INSERT], shadow.per_cmd[CMD_DELETE],
                 shadow.per_cmd[CMD_SEARCH], shadow.hits, shadow.per_cmd[CMD_READ]);
        $display("%0d clears; peak count %0d, %0d full and %0d range rejects, %0d results checked.",
                 shadow.per_cmd[CMD_CLEAR], shadow.peak, shadow.rejects_full,
                 shadow.rejects_range, shadow.results_seen);
        if (shadow.failures == 0 && shadow.pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== positional_array_insert_delete_search.f =====
src/paids_pkg.sv
src/paids_ram.sv
src/positional_array_insert_delete_search.sv
dv/positional_array_insert_delete_search_test.sv
